@@ sv/dta_pkg.sv @@
// ----------------------------------------------------------------------------
// dta_pkg: shared types and constants for the date and time adder
// Field widths, unit codes, calendar bounds, and the fixed-point reciprocals
// that turn constant divisions into multiplications.
// ----------------------------------------------------------------------------
package dta_pkg;

  localparam int MAX_YEAR     = 9999;
  localparam int SECS_PER_DAY = 60 * 60 * 24;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int AMT_W   = 32;
  localparam int UNIT_W  = 2;

  // Shifted year (year + 400) keeps every day number non-negative.
  localparam int YA_W   = 15;
  localparam int DAYS_W = 34;
  localparam int SOD_W  = 17;
  localparam int DOE_W  = 18;

  // Day-number window of years 1..MAX_YEAR in the shifted count.
  localparam int YA_MIN = 400;
  localparam int YA_MAX = MAX_YEAR + 400;
  localparam int W_MIN  = YA_MIN * 365 + YA_MIN / 4 - YA_MIN / 100 + YA_MIN / 400 + 306;
  localparam int W_MAX  = YA_MAX * 365 + YA_MAX / 4 - YA_MAX / 100 + YA_MAX / 400 + 275 + 30;
  localparam int WV_W   = $clog2(W_MAX + 1);
  localparam int ERA_W  = $clog2(W_MAX / 146097 + 1);
  localparam int ERA_S  = WV_W + 18;

  localparam logic signed [DAYS_W-1:0] W_LO = DAYS_W'(W_MIN);
  localparam logic signed [DAYS_W-1:0] W_HI = DAYS_W'(W_MAX);

  // Reciprocals: floor(2^S / D) + 1, exact for x * D < 2^S.
  localparam logic [WV_W:0] M_ERA    = (WV_W + 1)'((64'd1 << ERA_S) / 146097 + 1);
  localparam logic [18:0]   M_1460   = 19'((64'd1 << 29) / 1460 + 1);
  localparam logic [18:0]   M_36524  = 19'((64'd1 << 34) / 36524 + 1);
  localparam logic [18:0]   M_146096 = 19'((64'd1 << 36) / 146096 + 1);
  localparam logic [18:0]   M_365    = 19'((64'd1 << 27) / 365 + 1);
  localparam logic [9:0]    M_YOE100 = 10'((64'd1 << 16) / 100 + 1);
  localparam logic [11:0]   M_153    = 12'((64'd1 << 19) / 153 + 1);
  localparam logic [17:0]   M_HOUR   = 18'((64'd1 << 29) / 3600 + 1);
  localparam logic [12:0]   M_MIN    = 13'((64'd1 << 18) / 60 + 1);
  localparam logic [15:0]   M_Y100   = 16'((64'd1 << 22) / 100 + 1);
  localparam logic [15:0]   M_Y400   = 16'((64'd1 << 24) / 400 + 1);

  // Amount split: floor(2^32 / D), quotient low by at most one.
  localparam int SPLIT_S = 32;
  localparam int SPLIT_MW = 28;
  localparam logic [SPLIT_MW-1:0] M_SPLIT_SEC  = SPLIT_MW'((64'd1 << SPLIT_S) / SECS_PER_DAY);
  localparam logic [SPLIT_MW-1:0] M_SPLIT_MIN  = SPLIT_MW'((64'd1 << SPLIT_S) / 1440);
  localparam logic [SPLIT_MW-1:0] M_SPLIT_HOUR = SPLIT_MW'((64'd1 << SPLIT_S) / 24);

  typedef enum logic [UNIT_W-1:0] {
    UNIT_SEC  = 2'd0,
    UNIT_MIN  = 2'd1,
    UNIT_HOUR = 2'd2,
    UNIT_DAY  = 2'd3
  } unit_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
  } dta_time_t;

  typedef struct packed {
    logic                     valid;
    logic signed [DAYS_W-1:0] w;
    logic [SOD_W-1:0]         sod;
    dta_time_t                orig;
  } dta_span_t;

  typedef struct packed {
    logic      valid;
    dta_time_t t;
    logic      range_error;
  } dta_res_t;

  // Units per day for each unit code.
  function automatic logic [16:0] split_div(unit_t u);
    logic [16:0] d;
    unique case (u)
      UNIT_SEC:  d = 17'(SECS_PER_DAY);
      UNIT_MIN:  d = 17'd1440;
      UNIT_HOUR: d = 17'd24;
      UNIT_DAY:  d = 17'd1;
    endcase
    return d;
  endfunction

  function automatic logic [SPLIT_MW-1:0] split_mag(unit_t u);
    logic [SPLIT_MW-1:0] m;
    unique case (u)
      UNIT_SEC:  m = M_SPLIT_SEC;
      UNIT_MIN:  m = M_SPLIT_MIN;
      UNIT_HOUR: m = M_SPLIT_HOUR;
      UNIT_DAY:  m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [11:0] unit_scale(unit_t u);
    logic [11:0] s;
    unique case (u)
      UNIT_SEC:  s = 12'd1;
      UNIT_MIN:  s = 12'd60;
      UNIT_HOUR: s = 12'd3600;
      UNIT_DAY:  s = 12'd0;
    endcase
    return s;
  endfunction

  // First day of each month in a March-based year.
  function automatic logic [8:0] mp_start(logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

@@ sv/dta_ifs.sv @@
// ----------------------------------------------------------------------------
// dta_ifs: valid/ready channels of the date and time adder
// Input beat carries a start date, time, amount and unit; result beat
// carries the new date and time and the range flag.
// ----------------------------------------------------------------------------
interface dta_in_if import dta_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [YEAR_W-1:0]        cal_year;
  logic [MONTH_W-1:0]       cal_month;
  logic [DAY_W-1:0]         cal_day;
  logic [HOUR_W-1:0]        cal_hour;
  logic [MIN_W-1:0]         cal_minute;
  logic [SEC_W-1:0]         cal_second;
  logic signed [AMT_W-1:0]  amount;
  logic [UNIT_W-1:0]        unit;

  modport source (output valid, cal_year, cal_month, cal_day, cal_hour, cal_minute,
                  cal_second, amount, unit, input ready);
  modport sink   (input valid, cal_year, cal_month, cal_day, cal_hour, cal_minute,
                  cal_second, amount, unit, output ready);
endinterface

interface dta_out_if import dta_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  new_year;
  logic [MONTH_W-1:0] new_month;
  logic [DAY_W-1:0]   new_day;
  logic [HOUR_W-1:0]  new_hour;
  logic [MIN_W-1:0]   new_minute;
  logic [SEC_W-1:0]   new_second;
  logic               range_error;

  modport source (output valid, new_year, new_month, new_day, new_hour, new_minute,
                  new_second, range_error, input ready);
  modport sink   (input valid, new_year, new_month, new_day, new_hour, new_minute,
                  new_second, range_error, output ready);
endinterface

@@ sv/dta_span.sv @@
// ----------------------------------------------------------------------------
// dta_span: front half of the adder pipeline (four stages)
// Splits the amount into whole days and leftover seconds, builds the start
// day number, and sums both into a day count and a second of day.
// ----------------------------------------------------------------------------
module dta_span import dta_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  dta_time_t               in_time,
  input  logic signed [AMT_W-1:0] in_amount,
  input  logic [UNIT_W-1:0]       in_unit,
  output dta_span_t               span_o
);

  // stage 1
  logic [YA_W-1:0]    yp, ya;
  logic [MONTH_W-1:0] m_eff;
  logic               m_low;
  logic [3:0]         mp;
  logic [AMT_W-2:0]   u;
  logic [58:0]        sp;

  logic                    v1_r;
  dta_time_t               orig1_r;
  logic signed [AMT_W-1:0] amt1_r;
  unit_t                   unit1_r;
  logic [AMT_W-2:0]        u1_r;
  logic [26:0]             qe1_r;
  logic [23:0]             y365_1_r;
  logic [YA_W-1:0]         ya1_r;
  logic [8:0]              doy1_r;
  logic [SOD_W-1:0]        sod1_r;

  always_comb begin
    yp = YA_W'(in_time.year) + YA_W'(400);
    if (in_time.month == '0) begin
      m_eff = MONTH_W'(1);
    end else if (in_time.month > MONTH_W'(12)) begin
      m_eff = MONTH_W'(12);
    end else begin
      m_eff = in_time.month;
    end
    m_low = (m_eff <= MONTH_W'(2));
    ya    = m_low ? yp - YA_W'(1) : yp;
    mp    = m_low ? m_eff + 4'd9 : m_eff - 4'd3;
    u     = in_amount[AMT_W-1] ? ~in_amount[AMT_W-2:0] : in_amount[AMT_W-2:0];
    sp    = 59'(u) * 59'(split_mag(unit_t'(in_unit)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      orig1_r  <= in_time;
      amt1_r   <= in_amount;
      unit1_r  <= unit_t'(in_unit);
      u1_r     <= u;
      qe1_r    <= sp[SPLIT_S +: 27];
      y365_1_r <= 24'(ya) * 24'(365);
      ya1_r    <= ya;
      doy1_r   <= mp_start(mp);
      sod1_r   <= SOD_W'(in_time.hour) * SOD_W'(3600) + SOD_W'(in_time.minute) * SOD_W'(60)
                + SOD_W'(in_time.second);
    end
  end

  // stage 2: correct the quotient estimate, century terms
  logic [16:0]      d2;
  logic [43:0]      qd_full;
  logic [AMT_W-2:0] r_raw;
  logic             fix;
  logic [30:0]      c100_p;
  logic [30:0]      c400_p;

  logic                    v2_r;
  dta_time_t               orig2_r;
  logic signed [AMT_W-1:0] amt2_r;
  unit_t                   unit2_r;
  logic [26:0]             q2_r;
  logic [16:0]             r2_r;
  logic [23:0]             dna2_r;
  logic [7:0]              c100_2_r;
  logic [5:0]              c400_2_r;
  logic [8:0]              doy2_r;
  logic [SOD_W-1:0]        sod2_r;

  always_comb begin
    d2      = split_div(unit1_r);
    qd_full = 44'(qe1_r) * 44'(d2);
    r_raw   = u1_r - qd_full[AMT_W-2:0];
    fix     = (r_raw >= (AMT_W-1)'(d2));
    c100_p  = 31'(ya1_r) * 31'(M_Y100);
    c400_p  = 31'(ya1_r) * 31'(M_Y400);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      orig2_r  <= orig1_r;
      amt2_r   <= amt1_r;
      unit2_r  <= unit1_r;
      q2_r     <= fix ? qe1_r + 27'd1 : qe1_r;
      r2_r     <= fix ? 17'(r_raw - (AMT_W-1)'(d2)) : r_raw[16:0];
      dna2_r   <= y365_1_r + 24'(ya1_r >> 2);
      c100_2_r <= c100_p[22 +: 8];
      c400_2_r <= c400_p[24 +: 6];
      doy2_r   <= doy1_r;
      sod2_r   <= sod1_r;
    end
  end

  // stage 3: floor quotient and remainder, start day number
  logic [16:0]              d3, rf;
  logic [DAYS_W-1:0]        qs;
  logic [28:0]              rs_full;
  logic                     neg;

  logic                     v3_r;
  dta_time_t                orig3_r;
  logic signed [DAYS_W-1:0] qd3_r;
  logic [16:0]              rs3_r;
  logic [23:0]              dnb3_r;
  logic [SOD_W-1:0]         sod3_r;

  always_comb begin
    neg     = amt2_r[AMT_W-1];
    d3      = split_div(unit2_r);
    rf      = neg ? d3 - 17'd1 - r2_r : r2_r;
    qs      = DAYS_W'(q2_r);
    rs_full = 29'(rf) * 29'(unit_scale(unit2_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      orig3_r <= orig2_r;
      if (unit2_r == UNIT_DAY) begin
        qd3_r <= DAYS_W'(amt2_r);
        rs3_r <= '0;
      end else begin
        qd3_r <= neg ? ~qs : qs;
        rs3_r <= rs_full[16:0];
      end
      dnb3_r <= dna2_r + 24'(c400_2_r) + 24'(doy2_r) + 24'(orig2_r.day) - 24'(1)
              - 24'(c100_2_r);
      sod3_r <= sod2_r;
    end
  end

  // stage 4: second of day with day carry, total day count
  logic [SOD_W:0]           st;
  logic [1:0]               carry;
  logic [SOD_W:0]           sl;

  always_comb begin
    st = (SOD_W+1)'(rs3_r) + (SOD_W+1)'(sod3_r);
    if (st >= (SOD_W+1)'(2 * SECS_PER_DAY)) begin
      carry = 2'd2;
      sl    = st - (SOD_W+1)'(2 * SECS_PER_DAY);
    end else if (st >= (SOD_W+1)'(SECS_PER_DAY)) begin
      carry = 2'd1;
      sl    = st - (SOD_W+1)'(SECS_PER_DAY);
    end else begin
      carry = 2'd0;
      sl    = st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_o.valid <= 1'b0;
    end else if (en) begin
      span_o.valid <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      span_o.w    <= $signed(DAYS_W'(dnb3_r)) + qd3_r + $signed(DAYS_W'(carry));
      span_o.sod  <= sl[SOD_W-1:0];
      span_o.orig <= orig3_r;
    end
  end

endmodule

@@ sv/dta_civil.sv @@
// ----------------------------------------------------------------------------
// dta_civil: back half of the adder pipeline (eight stages)
// Turns the day count back into year, month and day, splits the second of
// day into hour, minute and second, and picks the result or the start.
// ----------------------------------------------------------------------------
module dta_civil import dta_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  dta_span_t span_i,
  output dta_res_t  res_o
);

  localparam int NST = 7;

  logic [NST-1:0] v_r;
  logic [NST-1:0] ok_r;
  dta_time_t      orig_r [NST];

  logic ok_in;
  assign ok_in = (span_i.w >= W_LO) && (span_i.w <= W_HI);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], span_i.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok_r      <= {ok_r[NST-2:0], ok_in};
      orig_r[0] <= span_i.orig;
      for (int k = 1; k < NST; k++) begin
        orig_r[k] <= orig_r[k-1];
      end
    end
  end

  // stage 5: era and hour
  logic [WV_W-1:0]     wv;
  logic [2*WV_W:0]     ep;
  logic [34:0]         hp;
  logic [WV_W-1:0]     wv5_r;
  logic [ERA_W-1:0]    era5_r;
  logic [HOUR_W-1:0]   hr5_r;
  logic [SOD_W-1:0]    sod5_r;

  always_comb begin
    wv = span_i.w[WV_W-1:0];
    ep = (2*WV_W+1)'(wv) * (2*WV_W+1)'(M_ERA);
    hp = 35'(span_i.sod) * 35'(M_HOUR);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wv5_r  <= wv;
      era5_r <= ep[ERA_S +: ERA_W];
      hr5_r  <= hp[29 +: HOUR_W];
      sod5_r <= span_i.sod;
    end
  end

  // stage 6: day of era, seconds within the hour
  logic [WV_W-1:0]   era_days;
  logic [WV_W-1:0]   doe_full;
  logic [SOD_W-1:0]  r1_full;
  logic [DOE_W-1:0]  doe6_r;
  logic [ERA_W-1:0]  era6_r;
  logic [HOUR_W-1:0] hr6_r;
  logic [11:0]       r1_6_r;

  always_comb begin
    era_days = WV_W'(era5_r) * WV_W'(146097);
    doe_full = wv5_r - era_days;
    r1_full  = sod5_r - SOD_W'(hr5_r) * SOD_W'(3600);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      doe6_r <= doe_full[DOE_W-1:0];
      era6_r <= era5_r;
      hr6_r  <= hr5_r;
      r1_6_r <= r1_full[11:0];
    end
  end

  // stage 7: leap corrections, minute
  logic [36:0]       pa, pb, pc;
  logic [24:0]       pm;
  logic [DOE_W-1:0]  doe7_r;
  logic [6:0]        a7_r;
  logic [2:0]        b7_r;
  logic              c7_r;
  logic [ERA_W-1:0]  era7_r;
  logic [HOUR_W-1:0] hr7_r;
  logic [MIN_W-1:0]  mi7_r;
  logic [11:0]       r1_7_r;

  always_comb begin
    pa = 37'(doe6_r) * 37'(M_1460);
    pb = 37'(doe6_r) * 37'(M_36524);
    pc = 37'(doe6_r) * 37'(M_146096);
    pm = 25'(r1_6_r) * 25'(M_MIN);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      doe7_r <= doe6_r;
      a7_r   <= pa[29 +: 7];
      b7_r   <= pb[34 +: 3];
      c7_r   <= pc[36];
      era7_r <= era6_r;
      hr7_r  <= hr6_r;
      mi7_r  <= pm[18 +: MIN_W];
      r1_7_r <= r1_6_r;
    end
  end

  // stage 8: adjusted day count, second
  logic [11:0]       sec_full;
  logic [DOE_W-1:0]  t8_r, doe8_r;
  logic [ERA_W-1:0]  era8_r;
  logic [HOUR_W-1:0] hr8_r;
  logic [MIN_W-1:0]  mi8_r;
  logic [SEC_W-1:0]  sec8_r;

  assign sec_full = r1_7_r - 12'(mi7_r) * 12'(60);

  always_ff @(posedge clk) begin
    if (en) begin
      t8_r   <= doe7_r - DOE_W'(a7_r) + DOE_W'(b7_r) - DOE_W'(c7_r);
      doe8_r <= doe7_r;
      era8_r <= era7_r;
      hr8_r  <= hr7_r;
      mi8_r  <= mi7_r;
      sec8_r <= sec_full[SEC_W-1:0];
    end
  end

  // stage 9: year of era
  logic [36:0]       py;
  logic [8:0]        yoe9_r;
  logic [DOE_W-1:0]  doe9_r;
  logic [ERA_W-1:0]  era9_r;
  logic [HOUR_W-1:0] hr9_r;
  logic [MIN_W-1:0]  mi9_r;
  logic [SEC_W-1:0]  sec9_r;

  assign py = 37'(t8_r) * 37'(M_365);

  always_ff @(posedge clk) begin
    if (en) begin
      yoe9_r <= py[27 +: 9];
      doe9_r <= doe8_r;
      era9_r <= era8_r;
      hr9_r  <= hr8_r;
      mi9_r  <= mi8_r;
      sec9_r <= sec8_r;
    end
  end

  // stage 10: day of year
  logic [18:0]       p100;
  logic [DOE_W-1:0]  ydays;
  logic [DOE_W-1:0]  doy_full;
  logic [8:0]        doy10_r, yoe10_r;
  logic [ERA_W-1:0]  era10_r;
  logic [HOUR_W-1:0] hr10_r;
  logic [MIN_W-1:0]  mi10_r;
  logic [SEC_W-1:0]  sec10_r;

  always_comb begin
    p100     = 19'(yoe9_r) * 19'(M_YOE100);
    ydays    = DOE_W'(yoe9_r) * DOE_W'(365) + DOE_W'(yoe9_r >> 2) - DOE_W'(p100[16 +: 2]);
    doy_full = doe9_r - ydays;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      doy10_r <= doy_full[8:0];
      yoe10_r <= yoe9_r;
      era10_r <= era9_r;
      hr10_r  <= hr9_r;
      mi10_r  <= mi9_r;
      sec10_r <= sec9_r;
    end
  end

  // stage 11: March-based month
  logic [10:0]       x5;
  logic [22:0]       pmp;
  logic [3:0]        mp11_r;
  logic [8:0]        doy11_r, yoe11_r;
  logic [ERA_W-1:0]  era11_r;
  logic [HOUR_W-1:0] hr11_r;
  logic [MIN_W-1:0]  mi11_r;
  logic [SEC_W-1:0]  sec11_r;

  always_comb begin
    x5  = 11'(doy10_r) * 11'(5) + 11'(2);
    pmp = 23'(x5) * 23'(M_153);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mp11_r  <= pmp[19 +: 4];
      doy11_r <= doy10_r;
      yoe11_r <= yoe10_r;
      era11_r <= era10_r;
      hr11_r  <= hr10_r;
      mi11_r  <= mi10_r;
      sec11_r <= sec10_r;
    end
  end

  // stage 12: calendar fields, range select
  logic [8:0]         dd;
  logic [MONTH_W-1:0] mm;
  logic [16:0]        yy;

  always_comb begin
    dd = doy11_r - mp_start(mp11_r) + 9'd1;
    mm = (mp11_r < 4'd10) ? mp11_r + 4'd3 : mp11_r - 4'd9;
    yy = 17'(yoe11_r) + 17'(era11_r) * 17'(400) + 17'(mm <= MONTH_W'(2)) - 17'(400);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_o.valid <= 1'b0;
    end else if (en) begin
      res_o.valid <= v_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ok_r[NST-1]) begin
        res_o.t.year   <= yy[YEAR_W-1:0];
        res_o.t.month  <= mm;
        res_o.t.day    <= dd[DAY_W-1:0];
        res_o.t.hour   <= hr11_r;
        res_o.t.minute <= mi11_r;
        res_o.t.second <= sec11_r;
        res_o.range_error <= 1'b0;
      end else begin
        res_o.t           <= orig_r[NST-1];
        res_o.range_error <= 1'b1;
      end
    end
  end

endmodule

@@ sv/gregorian_datetime_add_unit.sv @@
// ----------------------------------------------------------------------------
// gregorian_datetime_add_unit: add seconds, minutes, hours or days to a
// Gregorian date and time
// Twelve-stage pipeline; one beat in and out per clock unless stalled.
// ----------------------------------------------------------------------------
// Each input beat carries a start date and time and a signed amount in one
// of four units; each result beat carries the moment that lies that far
// away, with leap years by the 4/100/400 rule. If the result year falls
// outside 1..MAX_YEAR, the start is returned unchanged with range_error set.
// The block takes one beat every clock while the pipeline does not hold.
// The whole pipeline holds when a result waits at the output and the sink
// is not ready, so in_ch.ready drops only then. Start fields out of their
// calendar range count linearly (month is clamped to 1..12, day 0 is the
// last day of the month before).
// ----------------------------------------------------------------------------
module gregorian_datetime_add_unit import dta_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  dta_in_if.sink     in_ch,
  dta_out_if.source  out_ch
);

  logic      en;
  dta_time_t in_time;
  dta_span_t span;
  dta_res_t  res;

  // Advance every stage unless the output beat is stuck.
  assign en          = !res.valid || out_ch.ready;
  assign in_ch.ready = en;

  assign in_time.year   = in_ch.cal_year;
  assign in_time.month  = in_ch.cal_month;
  assign in_time.day    = in_ch.cal_day;
  assign in_time.hour   = in_ch.cal_hour;
  assign in_time.minute = in_ch.cal_minute;
  assign in_time.second = in_ch.cal_second;

  // Stages 1-4: amount split into days plus seconds, start day number.
  dta_span u_span (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .in_time   (in_time),
    .in_amount (in_ch.amount),
    .in_unit   (in_ch.unit),
    .span_o    (span)
  );

  // Stages 5-12: day count back to a calendar date; last stage is the
  // output register.
  dta_civil u_civil (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .span_i (span),
    .res_o  (res)
  );

  assign out_ch.valid       = res.valid;
  assign out_ch.new_year    = res.t.year;
  assign out_ch.new_month   = res.t.month;
  assign out_ch.new_day     = res.t.day;
  assign out_ch.new_hour    = res.t.hour;
  assign out_ch.new_minute  = res.t.minute;
  assign out_ch.new_second  = res.t.second;
  assign out_ch.range_error = res.range_error;

endmodule
